[rtl/sfla_pkg.sv]
// Shared types and codes for the sorted free-list block allocator.
// Holds the request/response word layouts and status codes; no dependencies.
package sfla_pkg;

    localparam int BLK_W  = 9;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 10;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DOUBLE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_UNUSED = 2'd3;

    typedef struct packed {
        logic             func;
        logic [BLK_W-1:0] block;
    } req_t;

    typedef struct packed {
        logic [BLK_W-1:0]  block_out;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  free_count;
    } rsp_t;

endpackage

[rtl/sfla_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
module sfla_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/sorted_free_list_block_allocator.sv]
// Top level of the sorted free-list block allocator.
// Uses sfla_pkg (word types, status codes) and sfla_ram (forward link store).
//
// Keeps the free blocks of a pool of NUM_BLOCKS blocks in a singly walked,
// address-ordered list whose forward links live in one RAM. After reset a
// clearing pass loads the initial chain 0 -> 1 -> ...; no request is taken
// until it ends. An allocate makes one RAM read of the head's link. A free
// walks past the free blocks below the freed one; the walk issues one RAM
// read per list entry. If the block is already free nothing is written;
// else its link is written and, unless it becomes the new head, so is the
// link of its predecessor. A rejected free (index out of range) or an
// allocate on an empty list goes straight to its result. Results sit in an
// output register, so the next request is taken while a finished result
// still waits on m_ready; a second finished result holds the block until
// the first one leaves.
module sorted_free_list_block_allocator #(
    parameter int NUM_BLOCKS = 512  // 2 .. 512, bounded by the 9-bit block field
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sfla_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output sfla_pkg::rsp_t m_data
);

    localparam int IDX_W  = $clog2(NUM_BLOCKS);
    localparam int LINK_W = $clog2(NUM_BLOCKS + 1);
    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_BLOCKS);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_BLOCKS - 1);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_ALLOC = 7'b0000100,
        ST_WALK  = 7'b0001000,
        ST_FIX   = 7'b0010000,
        ST_LINK  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic              m_valid_reg, m_valid_next;
    sfla_pkg::rsp_t    m_data_reg, m_data_next;
    sfla_pkg::rsp_t    res_reg, res_next;
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [LINK_W-1:0] before_reg, before_next;
    logic [LINK_W-1:0] blk_reg, blk_next;
    logic [LINK_W-1:0] steps_reg, steps_next;
    logic              first_reg, first_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [LINK_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [LINK_W-1:0] ram_rdata;

    logic [LINK_W-1:0] rd_link;
    logic [LINK_W-1:0] cur_w;
    logic              walk_go;
    logic [LINK_W-1:0] cnt_dec;
    logic [LINK_W-1:0] cnt_inc;

    sfla_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_BLOCKS)
    ) u_next_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // any out-of-range link reads as end of list
    assign rd_link = (ram_rdata >= LINK_NONE) ? LINK_NONE : ram_rdata;
    // first walk step starts at the head, later ones at the link just read
    assign cur_w   = first_reg ? head_reg : rd_link;
    assign walk_go = (cur_w != LINK_NONE) && (cur_w < blk_reg) && (steps_reg < LINK_NONE);
    assign cnt_dec = (cnt_reg != '0) ? cnt_reg - LINK_W'(1) : cnt_reg;
    assign cnt_inc = (cnt_reg < LINK_NONE) ? cnt_reg + LINK_W'(1) : cnt_reg;

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        cnt_next     = cnt_reg;
        clr_next     = clr_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        res_next     = res_reg;
        cur_next     = cur_reg;
        before_next  = before_reg;
        blk_next     = blk_reg;
        steps_next   = steps_reg;
        first_next   = first_reg;
        ram_we       = 1'b0;
        ram_waddr    = clr_reg;
        ram_wdata    = LINK_W'(clr_reg) + LINK_W'(1);
        ram_raddr    = head_reg[IDX_W-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                // entry k links to k+1; the last one gets NUM_BLOCKS (none)
                ram_we = 1'b1;
                if (clr_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + IDX_W'(1);
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.func == sfla_pkg::FUNC_ALLOC) begin
                        if (head_reg == LINK_NONE) begin
                            res_next.block_out  = '0;
                            res_next.status     = sfla_pkg::STAT_EMPTY;
                            res_next.free_count = sfla_pkg::CNT_W'(cnt_reg);
                            state_next          = ST_DONE;
                        end else begin
                            state_next = ST_ALLOC;
                        end
                    end else if (sfla_pkg::CNT_W'(s_data.block) >=
                                 sfla_pkg::CNT_W'(NUM_BLOCKS)) begin
                        res_next.block_out  = s_data.block;
                        res_next.status     = sfla_pkg::STAT_DOUBLE;
                        res_next.free_count = sfla_pkg::CNT_W'(cnt_reg);
                        state_next          = ST_DONE;
                    end else begin
                        blk_next    = LINK_W'(s_data.block);
                        before_next = LINK_NONE;
                        steps_next  = '0;
                        first_next  = 1'b1;
                        state_next  = ST_WALK;
                    end
                end
            end
            ST_ALLOC: begin
                head_next           = rd_link;
                cnt_next            = cnt_dec;
                res_next.block_out  = sfla_pkg::BLK_W'(head_reg);
                res_next.status     = sfla_pkg::STAT_OK;
                res_next.free_count = sfla_pkg::CNT_W'(cnt_dec);
                state_next          = ST_DONE;
            end
            ST_WALK: begin
                if (walk_go) begin
                    ram_raddr   = cur_w[IDX_W-1:0];
                    before_next = cur_w;
                    steps_next  = steps_reg + LINK_W'(1);
                    first_next  = 1'b0;
                end else begin
                    cur_next   = cur_w;
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                res_next.block_out = sfla_pkg::BLK_W'(blk_reg);
                if (cur_reg == blk_reg) begin
                    res_next.status     = sfla_pkg::STAT_DOUBLE;
                    res_next.free_count = sfla_pkg::CNT_W'(cnt_reg);
                    state_next          = ST_DONE;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = blk_reg[IDX_W-1:0];
                    ram_wdata = cur_reg;
                    if (before_reg == LINK_NONE) begin
                        head_next           = blk_reg;
                        cnt_next            = cnt_inc;
                        res_next.status     = sfla_pkg::STAT_OK;
                        res_next.free_count = sfla_pkg::CNT_W'(cnt_inc);
                        state_next          = ST_DONE;
                    end else begin
                        state_next = ST_LINK;
                    end
                end
            end
            ST_LINK: begin
                // predecessor now points at the freed block
                ram_we              = 1'b1;
                ram_waddr           = before_reg[IDX_W-1:0];
                ram_wdata           = blk_reg;
                cnt_next            = cnt_inc;
                res_next.status     = sfla_pkg::STAT_OK;
                res_next.free_count = sfla_pkg::CNT_W'(cnt_inc);
                state_next          = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            head_reg    <= '0;
            cnt_reg     <= LINK_NONE;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            cnt_reg     <= cnt_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        res_reg    <= res_next;
        cur_reg    <= cur_next;
        before_reg <= before_next;
        blk_reg    <= blk_next;
        steps_reg  <= steps_next;
        first_reg  <= first_next;
    end

    // free count can never pass the pool size
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= LINK_NONE)
        else $error("free count above pool size");

    // an empty list has no head, and vice versa, whenever a request can enter
    a_head_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> ((cnt_reg == '0) == (head_reg == LINK_NONE)))
        else $error("head and free count disagree");

    // an empty-list result always reports block 0 and no free blocks
    a_empty_rsp: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == sfla_pkg::STAT_EMPTY) |->
        (m_data.block_out == '0 && m_data.free_count == '0))
        else $error("bad empty-list result word");

    // no unused status code leaves the block, and no word during clearing
    a_rsp_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status != sfla_pkg::STAT_UNUSED && state_reg != ST_CLEAR))
        else $error("bad result word");

endmodule

[tb/sv/sorted_free_list_block_allocator_tb.sv]
// Self-checking testbench for the sorted free-list block allocator.
// Drives request words, predicts every response word, checks them in order.
// Depends on sfla_pkg and sorted_free_list_block_allocator.
`timescale 1ns / 1ps

module sorted_free_list_block_allocator_tb;

    localparam int          NB             = 512;
    localparam int unsigned LINK_END       = NB;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          MAX_ERR_PRINTS = 10;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    sfla_pkg::req_t s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    sfla_pkg::rsp_t m_data;

    sorted_free_list_block_allocator #(
        .NUM_BLOCKS(NB)
    ) i_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // allocator state as predicted
    int unsigned free_next [NB];
    int unsigned free_head;
    int unsigned free_total;

    sfla_pkg::rsp_t pending_rsp [$];
    int             error_count = 0;

    // blocks currently handed out, used to build well-formed frees
    int unsigned owned_blocks [$];

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_len        = 0;
    int hold_id         = 0;
    int hold_seen       = 0;
    int hold_left       = 0;
    int idle_cycles     = 0;

    function automatic void reset_free_list();
        for (int k = 0; k < NB; k++) begin
            free_next[k] = 32'(k + 1);
        end
        free_head  = 0;
        free_total = NB;
    endfunction

    function automatic sfla_pkg::rsp_t predict_rsp(sfla_pkg::req_t w);
        sfla_pkg::rsp_t r;
        int unsigned    b;
        int unsigned    cur;
        int unsigned    prv;
        int unsigned    steps;
        r = '0;
        b = 32'(w.block);
        if (w.func == sfla_pkg::FUNC_ALLOC) begin
            if (free_head >= LINK_END) begin
                r.block_out  = '0;
                r.status     = sfla_pkg::STAT_EMPTY;
                r.free_count = sfla_pkg::CNT_W'(free_total);
            end else begin
                r.block_out = sfla_pkg::BLK_W'(free_head);
                cur = free_next[free_head];
                free_head = (cur >= LINK_END) ? LINK_END : cur;
                if (free_total > 0) free_total--;
                r.status     = sfla_pkg::STAT_OK;
                r.free_count = sfla_pkg::CNT_W'(free_total);
            end
            return r;
        end
        r.block_out = sfla_pkg::BLK_W'(b);
        // an index past the pool is rejected like a double free
        if (b >= LINK_END) begin
            r.status     = sfla_pkg::STAT_DOUBLE;
            r.free_count = sfla_pkg::CNT_W'(free_total);
            return r;
        end
        cur   = (free_head >= LINK_END) ? LINK_END : free_head;
        prv   = LINK_END;
        steps = 0;
        while (cur != LINK_END && cur < b && steps < NB) begin
            prv = cur;
            cur = free_next[cur];
            if (cur >= LINK_END) cur = LINK_END;
            steps++;
        end
        if (cur == b) begin
            r.status     = sfla_pkg::STAT_DOUBLE;
            r.free_count = sfla_pkg::CNT_W'(free_total);
            return r;
        end
        free_next[b] = cur;
        if (prv == LINK_END) free_head = b;
        else free_next[prv] = b;
        if (free_total < NB) free_total++;
        r.status     = sfla_pkg::STAT_OK;
        r.free_count = sfla_pkg::CNT_W'(free_total);
        return r;
    endfunction

    // Offers one request word, waits for its acceptance, then records the
    // expected response. s_valid stays high when no gap follows.
    task automatic send_word(input sfla_pkg::req_t w);
        int             n;
        sfla_pkg::rsp_t r;
        n = 0;
        while (n < 40 && $urandom_range(99) < sender_idle_pct) n++;
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = predict_rsp(w);
        pending_rsp.push_back(r);
        if (r.status == sfla_pkg::STAT_OK) begin
            if (w.func == sfla_pkg::FUNC_ALLOC) begin
                owned_blocks.push_back(32'(r.block_out));
            end else begin
                for (int i = 0; i < owned_blocks.size(); i++) begin
                    if (owned_blocks[i] == 32'(w.block)) begin
                        owned_blocks.delete(i);
                        break;
                    end
                end
            end
        end
    endtask

    task automatic send_alloc();
        sfla_pkg::req_t w;
        w.func  = sfla_pkg::FUNC_ALLOC;
        w.block = sfla_pkg::BLK_W'($urandom_range(NB - 1));  // ignored by the block
        send_word(w);
    endtask

    task automatic send_free(input int unsigned b);
        sfla_pkg::req_t w;
        w.func  = sfla_pkg::FUNC_FREE;
        w.block = sfla_pkg::BLK_W'(b);
        send_word(w);
    endtask

    task automatic test_directed();
        send_free(0);          // head already free
        send_free(NB - 1);     // deepest walk, finds itself
        send_free(256);
        send_alloc();          // 0
        send_alloc();          // 1
        send_alloc();          // 2
        send_free(1);          // insert at head
        send_free(1);          // double free
        send_free(0);          // new head below old head
        send_alloc();
        send_free(2);          // insert in the middle
        send_free(2);
        send_free(NB - 1);
        send_alloc();
        send_alloc();
        send_free(0);
        send_free(1);
        send_free(170);
        send_free(341);
    endtask

    // Receiver holds off while allocs pile up, then the pool is drained past
    // empty; afterwards frees build a list from nothing, with tail appends.
    task automatic test_drain_under_backpressure();
        sender_idle_pct = 13;
        recv_stall_pct  = 13;
        hold_len = 3000;
        hold_id++;
        while (free_total > 0) send_alloc();
        repeat (4) send_alloc();
        send_free(300);        // into an empty list
        send_free(400);        // beyond the tail
        send_free(NB - 1);
        send_free(100);        // new head
        send_free(400);
        send_alloc();
        send_free(100);
    endtask

    task automatic test_random_mix(input int n_words, input int idle_pct, input int stall_pct);
        int          r;
        int          idx;
        int unsigned b;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        for (int i = 0; i < n_words; i++) begin
            r = $urandom_range(99);
            if (r < 55 && owned_blocks.size() > 0) begin
                idx = $urandom_range(owned_blocks.size() - 1);
                send_free(owned_blocks[idx]);
            end else if (r < 90) begin
                send_alloc();
            end else begin
                b = $urandom_range(NB - 1);
                send_free(b);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (hold_id != hold_seen) begin
            hold_seen = hold_id;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        sfla_pkg::rsp_t exp_rsp;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                error_count++;
                if (error_count <= MAX_ERR_PRINTS)
                    $display("unexpected response word: block %0d status %0d count %0d",
                             m_data.block_out, m_data.status, m_data.free_count);
            end else begin
                exp_rsp = pending_rsp.pop_front();
                if (m_data.block_out !== exp_rsp.block_out
                        || m_data.status !== exp_rsp.status
                        || m_data.free_count !== exp_rsp.free_count) begin
                    error_count++;
                    if (error_count <= MAX_ERR_PRINTS)
                        $display({"mismatch: block %0d/%0d status %0d/%0d ",
                                  "count %0d/%0d (exp/act)"},
                                 exp_rsp.block_out, m_data.block_out,
                                 exp_rsp.status, m_data.status,
                                 exp_rsp.free_count, m_data.free_count);
                end
            end
        end
    end

    // nothing moving on either channel for too long ends the run
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sorted_free_list_block_allocator_tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        reset_free_list();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_drain_under_backpressure();
        test_random_mix(100, 0, 0);
        test_random_mix(100, 75, 0);
        test_random_mix(100, 0, 75);
        test_random_mix(100, 13, 13);
        s_valid <= 1'b0;

        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (NB + 16) @(posedge aclk);
        if (error_count == 0) begin
            $display("sorted_free_list_block_allocator_tb: clean");
        end else begin
            $display("sorted_free_list_block_allocator_tb: errors");
        end
        $finish;
    end

endmodule

[files.f]
rtl/sfla_pkg.sv
rtl/sfla_ram.sv
rtl/sorted_free_list_block_allocator.sv
tb/sv/sorted_free_list_block_allocator_tb.sv
